// File: rtl/core/tfn_pkg.sv
`timescale 1ns / 1ps

package tfn_pkg;

  // Field widths.
  localparam int CW = 16;         // corner coordinate, Q8.8
  localparam int EW = CW + 1;     // edge vector component
  localparam int PW = 2 * EW;     // product of an e1 and an e2 component
  localparam int XW = PW + 1;     // cross product component
  localparam int PSW = 6;         // bit position within a cross magnitude
  localparam int NW = 30;         // normalized magnitude, top bit at NW-1
  localparam int QSW = 2 * NW;    // square of a normalized magnitude
  localparam int SW = QSW + 2;    // sum of three squares
  localparam int LW = SW / 2;     // integer square root
  localparam int RW = SW + 1;     // square root remainder and trial value
  localparam int F = 14;          // fraction bits of the normal
  localparam int QW = F + 1;      // quotient bits, q <= 2^F
  localparam int DW = LW + 1;     // divisor 2L
  localparam int OW = 16;         // normal component

  // Data that rides along with the square root.
  typedef struct packed {
    logic [2:0][NW-1:0] mag;
    logic [2:0]         neg;
    logic               degen;
  } sqrt_side_t;

  // Data that rides along with the divider.
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } div_side_t;

endpackage

// File: rtl/core/tfn_if.sv
`timescale 1ns / 1ps

// Triangle corners, one item per triangle.
interface tfn_tri_if;
  import tfn_pkg::*;
  logic valid;
  logic ready;
  logic signed [CW-1:0] a_x, a_y, a_z;
  logic signed [CW-1:0] b_x, b_y, b_z;
  logic signed [CW-1:0] c_x, c_y, c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

// Unit normal result, one item per triangle.
interface tfn_nrm_if;
  import tfn_pkg::*;
  logic valid;
  logic ready;
  logic signed [OW-1:0] normal_x, normal_y, normal_z;
  logic degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// File: rtl/core/triangle_face_normal.sv
`timescale 1ns / 1ps

// Channel   Modport        Payload
// tri_in    tfn_tri_if     corners a, b, c as signed Q8.8 (x, y, z each)
// nrm_out   tfn_nrm_if     unit normal as signed Q1.14, degenerate flag
//
// One item enters per cycle while the pipeline advances; each item passes
// through the front stages, the 31 root stages and the 15 divider stages.
// Reset clears every stage valid bit; payload registers are not reset.
// The whole pipeline advances together whenever the output register is
// empty or its item is taken, so a stall freezes every stage in place.
module triangle_face_normal import tfn_pkg::*; (
  input logic     clk,
  input logic     rst,
  tfn_tri_if.sink tri_in,
  tfn_nrm_if.source nrm_out
);

  logic adv;
  logic o_vld;

  assign adv          = !o_vld || nrm_out.ready;
  assign tri_in.ready = adv;

  // Stage 1: edge vectors.
  logic s1_vld;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= tri_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1[0] <= {tri_in.b_x[CW-1], tri_in.b_x} - {tri_in.a_x[CW-1], tri_in.a_x};
      e1[1] <= {tri_in.b_y[CW-1], tri_in.b_y} - {tri_in.a_y[CW-1], tri_in.a_y};
      e1[2] <= {tri_in.b_z[CW-1], tri_in.b_z} - {tri_in.a_z[CW-1], tri_in.a_z};
      e2[0] <= {tri_in.c_x[CW-1], tri_in.c_x} - {tri_in.a_x[CW-1], tri_in.a_x};
      e2[1] <= {tri_in.c_y[CW-1], tri_in.c_y} - {tri_in.a_y[CW-1], tri_in.a_y};
      e2[2] <= {tri_in.c_z[CW-1], tri_in.c_z} - {tri_in.a_z[CW-1], tri_in.a_z};
    end
  end

  // Stage 2: the edge products of the cross product, one per entry of p.
  logic s2_vld;
  logic signed [PW-1:0] p [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p[0] <= e1[1] * e2[2];
      p[1] <= e1[2] * e2[1];
      p[2] <= e1[2] * e2[0];
      p[3] <= e1[0] * e2[2];
      p[4] <= e1[0] * e2[1];
      p[5] <= e1[1] * e2[0];
    end
  end

  // Stage 3: cross components split into sign and magnitude.
  logic s3_vld;
  logic [XW-1:0] s3_mag [3];
  logic [2:0]    s3_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_cross
    logic [XW-1:0] diff;

    assign diff = {p[2*i][PW-1], p[2*i]} - {p[2*i+1][PW-1], p[2*i+1]};

    always_ff @(posedge clk) begin
      if (adv) begin
        s3_neg[i] <= diff[XW-1];
        s3_mag[i] <= diff[XW-1] ? XW'(-diff) : diff;
      end
    end
  end

  // Stage 4: largest magnitude.
  logic s4_vld;
  logic [XW-1:0] s4_mag [3];
  logic [2:0]    s4_neg;
  logic [XW-1:0] s4_max;
  logic [XW-1:0] max01;

  assign max01 = (s3_mag[0] > s3_mag[1]) ? s3_mag[0] : s3_mag[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_mag <= s3_mag;
      s4_neg <= s3_neg;
      s4_max <= (s3_mag[2] > max01) ? s3_mag[2] : max01;
    end
  end

  // Stage 5: position of the leading one of the largest magnitude and the zero test.
  logic s5_vld;
  logic [XW-1:0]  s5_mag [3];
  logic [2:0]     s5_neg;
  logic           s5_degen;
  logic [PSW-1:0] s5_pos;
  logic [PSW-1:0] lead;

  always_comb begin
    lead = '0;
    for (int b = 0; b < XW; b++) begin
      if (s4_max[b]) begin
        lead = PSW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (adv) begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_mag   <= s4_mag;
      s5_neg   <= s4_neg;
      s5_degen <= (s4_max == '0);
      s5_pos   <= lead;
    end
  end

  // Stage 6: common shift that puts the leading one at bit NW-1.
  logic s6_vld;
  logic [2:0][NW-1:0] s6_mag;
  logic [2:0]         s6_neg;
  logic               s6_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (adv) begin
      s6_vld <= s5_vld;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_norm
    logic [XW-1:0] shifted;

    assign shifted = (s5_pos >= PSW'(NW)) ? (s5_mag[i] >> (s5_pos - PSW'(NW - 1)))
                                          : (s5_mag[i] << (PSW'(NW - 1) - s5_pos));

    always_ff @(posedge clk) begin
      if (adv) begin
        s6_mag[i] <= shifted[NW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_neg   <= s5_neg;
      s6_degen <= s5_degen;
    end
  end

  // Stage 7: squares of the normalized magnitudes.
  logic s7_vld;
  logic [QSW-1:0] s7_sq [3];
  sqrt_side_t     s7_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (adv) begin
      s7_vld <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s7_sq[i] <= s6_mag[i] * s6_mag[i];
      end
      s7_side.mag   <= s6_mag;
      s7_side.neg   <= s6_neg;
      s7_side.degen <= s6_degen;
    end
  end

  // Stage 8: sum of squares.
  logic s8_vld;
  logic [SW-1:0] s8_sum;
  sqrt_side_t    s8_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else if (adv) begin
      s8_vld <= s7_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_sum  <= SW'(s7_sq[0]) + SW'(s7_sq[1]) + SW'(s7_sq[2]);
      s8_side <= s7_side;
    end
  end

  // Length of the normalized vector.
  logic          sq_vld;
  logic [LW-1:0] sq_root;
  sqrt_side_t    sq_side;

  tfn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s8_vld),
    .sum       (s8_sum),
    .side_in   (s8_side),
    .out_valid (sq_vld),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  // Per-component scaling by the length, rounded half up.
  logic               dv_vld;
  logic [2:0][QW-1:0] dv_q;
  div_side_t          dv_side;

  tfn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq_vld),
    .root      (sq_root),
    .side_in   (sq_side),
    .out_valid (dv_vld),
    .quot      (dv_q),
    .side_out  (dv_side)
  );

  // Output register: sign applied, zero normal for a degenerate triangle.
  logic signed [OW-1:0] o_n [3];
  logic                 o_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_side.degen) begin
          o_n[i] <= '0;
        end else if (dv_side.neg[i]) begin
          o_n[i] <= -OW'(dv_q[i]);
        end else begin
          o_n[i] <= OW'(dv_q[i]);
        end
      end
      o_degen <= dv_side.degen;
    end
  end

  assign nrm_out.valid      = o_vld;
  assign nrm_out.normal_x   = o_n[0];
  assign nrm_out.normal_y   = o_n[1];
  assign nrm_out.normal_z   = o_n[2];
  assign nrm_out.degenerate = o_degen;

endmodule

// File: rtl/core/tfn_sqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root, one root bit per stage.
module tfn_sqrt import tfn_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [SW-1:0] sum,
  input  sqrt_side_t    side_in,
  output logic          out_valid,
  output logic [LW-1:0] root,
  output sqrt_side_t    side_out
);

  logic [LW:0]   vld;
  logic [RW-1:0] rem  [LW+1];
  logic [LW-1:0] r    [LW+1];
  sqrt_side_t    side [LW+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = {1'b0, sum};
  assign r[0]    = '0;
  assign side[0] = side_in;

  for (genvar g = 0; g < LW; g++) begin : g_stage
    localparam int K = LW - 1 - g;
    logic [RW-1:0] trial;

    // Candidate square growth when root bit K is set.
    assign trial = (RW'(r[g]) << (K + 1)) | (RW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (adv) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[g+1] <= side[g];
        if (rem[g] >= trial) begin
          rem[g+1] <= rem[g] - trial;
          r[g+1]   <= r[g] | (LW'(1) << K);
        end else begin
          rem[g+1] <= rem[g];
          r[g+1]   <= r[g];
        end
      end
    end
  end

  assign out_valid = vld[LW];
  assign root      = r[LW];
  assign side_out  = side[LW];

endmodule

// File: rtl/core/tfn_div.sv
`timescale 1ns / 1ps

// Three-lane pipelined restoring divider, one quotient bit per stage.
// Each lane forms floor((m * 2^(F+1) + L) / (2L)).
module tfn_div import tfn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [LW-1:0]      root,
  input  sqrt_side_t         side_in,
  output logic               out_valid,
  output logic [2:0][QW-1:0] quot,
  output div_side_t          side_out
);

  logic [QW:0]       vld;
  logic [DW-1:0]     den  [QW+1];
  logic [QW-1:0]     low  [QW+1];
  logic [2:0][DW-1:0] rem [QW+1];
  logic [2:0][QW-1:0] q   [QW+1];
  div_side_t         side [QW+1];

  // The upper numerator part m + (L >> (F+1)) is already below 2L.
  assign vld[0]        = in_valid;
  assign den[0]        = {root, 1'b0};
  assign low[0]        = root[QW-1:0];
  assign side[0].neg   = side_in.neg;
  assign side[0].degen = side_in.degen;
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem[0][l] = DW'(side_in.mag[l]) + DW'(root >> QW);
    assign q[0][l]   = '0;
  end

  for (genvar g = 0; g < QW; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (adv) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den[g+1]  <= den[g];
        low[g+1]  <= low[g];
        side[g+1] <= side[g];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DW:0] shifted;

      assign shifted = {rem[g][l], low[g][QW-1-g]};

      always_ff @(posedge clk) begin
        if (adv) begin
          if (shifted >= {1'b0, den[g]}) begin
            rem[g+1][l] <= DW'(shifted - {1'b0, den[g]});
            q[g+1][l]   <= {q[g][l][QW-2:0], 1'b1};
          end else begin
            rem[g+1][l] <= shifted[DW-1:0];
            q[g+1][l]   <= {q[g][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign quot      = q[QW];
  assign side_out  = side[QW];

endmodule

// File: rtl/core/tfn_check.sv
`timescale 1ns / 1ps

// Port-level checks on the normal output.
module tfn_check import tfn_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [OW-1:0] nx,
  input logic signed [OW-1:0] ny,
  input logic signed [OW-1:0] nz,
  input logic                 degen
);

  // A degenerate triangle always reports a zero normal.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degen |-> nx == '0 && ny == '0 && nz == '0)
    else $error("degenerate item with nonzero normal");

  // Every component stays within unit magnitude.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> nx >= -16384 && nx <= 16384 && ny >= -16384 && ny <= 16384
                  && nz >= -16384 && nz <= 16384)
    else $error("normal component out of range");

  // A nondegenerate normal has at least one component of notable size.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degen |-> nx > 4096 || nx < -4096 || ny > 4096 || ny < -4096
                            || nz > 4096 || nz < -4096)
    else $error("nondegenerate normal is too short");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(nx) && $stable(ny) && $stable(nz)
                                && $stable(degen))
    else $error("stalled result changed");

endmodule

bind triangle_face_normal tfn_check u_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (nrm_out.valid),
  .out_ready (nrm_out.ready),
  .nx        (nrm_out.normal_x),
  .ny        (nrm_out.normal_y),
  .nz        (nrm_out.normal_z),
  .degen     (nrm_out.degenerate)
);
